// ===== rtl/core/leap_compensated_elapsed_timer_assert.svh =====
// ---------------------------------------------------------------------------
// leap compensated elapsed timer assertion macros
// concurrent checks that compile away when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef LEAP_COMPENSATED_ELAPSED_TIMER_ASSERT_SVH
`define LEAP_COMPENSATED_ELAPSED_TIMER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LCET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define LCET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LCET_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define LCET_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/lcet_pkg.sv =====
// ---------------------------------------------------------------------------
// lcet_pkg
// shared types and constants of the leap compensated elapsed timer
// ---------------------------------------------------------------------------
`default_nettype none

package lcet_pkg;

   localparam int unsigned DATA_W      = 64;
   localparam int unsigned FREQ_W      = 63;
   localparam int unsigned TICK_W      = 32;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned DIV_CNT_W   = 6;

   localparam logic [DATA_W-1:0] MS_SCALE      = 64'd1000;
   localparam logic [DATA_W-1:0] US_SCALE      = 64'd1000000;
   localparam logic [TICK_W-1:0] LEAP_LIMIT_MS = 32'd100;
   localparam logic [FREQ_W-1:0] FREQ_RESET    = 63'd10000000;

   typedef enum logic [1:0] {
      ACT_RESTART = 2'd0,
      ACT_READ_MS = 2'd1,
      ACT_READ_US = 2'd2,
      ACT_NONE    = 2'd3
   } lcet_action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_WAIT,
      S_DIV_WAIT,
      S_CHECK,
      S_ADJUST,
      S_FINISH
   } lcet_state_type;

   typedef enum logic [1:0] {
      PH_MS,
      PH_OFF,
      PH_MS2,
      PH_US
   } lcet_phase_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lcet_unit_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/lcet_mul.sv =====
// ---------------------------------------------------------------------------
// lcet_mul
// shift-add multiplier, 64-bit wrapping product, one multiplier bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module lcet_mul (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [lcet_pkg::DATA_W-1:0]       op_a,
   input  wire logic [lcet_pkg::DATA_W-1:0]       op_b,
   output lcet_pkg::lcet_unit_status_type         status,
   output logic      [lcet_pkg::DATA_W-1:0]       product
);

   logic [lcet_pkg::DATA_W-1:0] a_ff, a_in;
   logic [lcet_pkg::DATA_W-1:0] b_ff, b_in;
   logic [lcet_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            // no multiplier bits left, product is final
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[lcet_pkg::DATA_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[lcet_pkg::DATA_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lcet_div.sv =====
// ---------------------------------------------------------------------------
// lcet_div
// restoring divider, signed dividend by unsigned divisor, truncating
// ---------------------------------------------------------------------------
`default_nettype none

module lcet_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [lcet_pkg::DATA_W-1:0]       dividend,
   input  wire logic [lcet_pkg::DATA_W-1:0]       divisor,
   output lcet_pkg::lcet_unit_status_type         status,
   output logic      [lcet_pkg::DATA_W-1:0]       quotient
);

   logic [lcet_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [lcet_pkg::DATA_W-1:0]    quo_ff, quo_in;
   logic [lcet_pkg::DATA_W-1:0]    dsr_ff, dsr_in;
   logic [lcet_pkg::DATA_W-1:0]    res_ff, res_in;
   logic [lcet_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           neg_ff, neg_in;
   logic                           zero_ff, zero_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [lcet_pkg::DATA_W:0]      shifted;
   logic [lcet_pkg::DATA_W:0]      trial;
   logic [lcet_pkg::DATA_W-1:0]    quo_next;

   always_comb begin
      shifted  = {rem_ff, quo_ff[lcet_pkg::DATA_W-1]};
      trial    = shifted - {1'b0, dsr_ff};
      quo_next = {quo_ff[lcet_pkg::DATA_W-2:0], ~trial[lcet_pkg::DATA_W]};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         neg_in  = dividend[lcet_pkg::DATA_W-1];
         quo_in  = dividend[lcet_pkg::DATA_W-1] ? (lcet_pkg::DATA_W'(0) - dividend)
                                                : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         zero_in = (divisor == '0);
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = trial[lcet_pkg::DATA_W] ? shifted[lcet_pkg::DATA_W-1:0]
                                          : trial[lcet_pkg::DATA_W-1:0];
         quo_in = quo_next;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (zero_ff) begin
               res_in = '0;
            end else if (neg_ff) begin
               res_in = lcet_pkg::DATA_W'(0) - quo_next;
            end else begin
               res_in = quo_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = res_ff;

endmodule

`default_nettype wire

// ===== rtl/core/leap_compensated_elapsed_timer.sv =====
// ---------------------------------------------------------------------------
// leap_compensated_elapsed_timer
// elapsed ms / us timer with fast counter leap detection and compensation
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake             payload
//   req_      in    req_valid/req_ready   action, fast_count, coarse_ticks
//   rsp_      out   rsp_valid/rsp_ready   elapsed_value, leap_seen
//   csr_      in    apb, pready tied high counter_frequency at offset 0
//
// restart and unused actions: go straight to the finish state, and the result
// beat is registered from there once the result register is free
// a read runs a shared shift-add multiplier, which steps through the bits of
// its second factor (ms or us scale, or the frequency in the offset scaling),
// and a restoring divider, with further passes of both after a leap. one
// item in flight; req_ready is low until its result is registered, and a
// waiting result beat does not block the next request
// reset clears state, baselines and frequency (to 10 MHz)
//
`default_nettype none

`include "leap_compensated_elapsed_timer_assert.svh"

module leap_compensated_elapsed_timer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_action,
   input  wire logic [lcet_pkg::FREQ_W-1:0]          req_fast_count,
   input  wire logic [lcet_pkg::TICK_W-1:0]          req_coarse_ticks,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [31:0]                          rsp_elapsed_value,
   output logic                                      rsp_leap_seen,
   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [lcet_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [lcet_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [lcet_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                      csr_pready
);

   localparam int unsigned DW = lcet_pkg::DATA_W;
   localparam int unsigned TW = lcet_pkg::TICK_W;

   // sequencer and item context
   lcet_pkg::lcet_state_type  state_ff, state_in;
   lcet_pkg::lcet_phase_type  phase_ff, phase_in;
   lcet_pkg::lcet_action_type action_ff, action_in;
   logic [TW-1:0]             coarse_ff, coarse_in;
   logic [DW-1:0]             elapsed_ff, elapsed_in;
   logic [DW-1:0]             value_ff, value_in;
   logic [DW-1:0]             scaled_ff, scaled_in;
   logic                      leap_ff, leap_in;

   // architectural state
   logic [lcet_pkg::FREQ_W-1:0] freq_ff, freq_in;
   logic [DW-1:0]               base_fast_ff, base_fast_in;
   logic [TW-1:0]               base_coarse_ff, base_coarse_in;
   logic [DW-1:0]               last_elapsed_ff, last_elapsed_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_value_ff, rsp_value_in;
   logic                      rsp_leap_ff, rsp_leap_in;

   // shared arithmetic units
   logic                          mul_start, div_start;
   logic [DW-1:0]                 mul_a, mul_b, mul_product;
   logic [DW-1:0]                 div_a, div_d, div_quotient;
   lcet_pkg::lcet_unit_status_type mul_status, div_status;

   // datapath terms
   logic          req_fire;
   logic          out_free;
   logic [DW-1:0] elapsed_new;
   logic [TW-1:0] check;
   logic [TW-1:0] diff;
   logic [TW-1:0] mag;
   logic          leap_hit;
   logic [DW-1:0] off64;
   logic [DW-1:0] growth;
   logic [DW-1:0] adjust;
   logic [DW-1:0] elapsed_adj;
   logic          csr_write;

   lcet_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .status  (mul_status),
      .product (mul_product)
   );

   lcet_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_d),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // request accepted only between items
   assign req_ready = (state_ff == lcet_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   // result register can take a new beat
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // elapsed fast count against the current baseline
   assign elapsed_new = {1'b0, req_fast_count} - base_fast_ff;

   // leap check: scaled ms against elapsed coarse ticks, 32-bit wrap
   assign check    = coarse_ff - base_coarse_ff;
   assign diff     = value_ff[TW-1:0] - check;
   assign mag      = diff[TW-1] ? (TW'(0) - diff) : diff;
   assign leap_hit = (mag > lcet_pkg::LEAP_LIMIT_MS);
   assign off64    = {{(DW-TW){diff[TW-1]}}, diff};

   // compensation: smaller of scaled offset and growth since last read
   assign growth      = elapsed_ff - last_elapsed_ff;
   assign adjust      = ($signed(scaled_ff) < $signed(growth)) ? scaled_ff : growth;
   assign elapsed_adj = elapsed_ff - adjust;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcet_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_action == lcet_pkg::ACT_READ_MS ||
                   req_action == lcet_pkg::ACT_READ_US) begin
                  state_in = lcet_pkg::S_MUL_WAIT;
               end else begin
                  state_in = lcet_pkg::S_FINISH;
               end
            end
         end
         lcet_pkg::S_MUL_WAIT: begin
            if (mul_status.done) begin
               state_in = lcet_pkg::S_DIV_WAIT;
            end
         end
         lcet_pkg::S_DIV_WAIT: begin
            if (div_status.done) begin
               unique case (phase_ff)
                  lcet_pkg::PH_MS:  state_in = lcet_pkg::S_CHECK;
                  lcet_pkg::PH_OFF: state_in = lcet_pkg::S_ADJUST;
                  default:          state_in = lcet_pkg::S_FINISH;
               endcase
            end
         end
         lcet_pkg::S_CHECK: begin
            if (!leap_hit && action_ff == lcet_pkg::ACT_READ_MS) begin
               state_in = lcet_pkg::S_FINISH;
            end else begin
               state_in = lcet_pkg::S_MUL_WAIT;
            end
         end
         lcet_pkg::S_ADJUST: begin
            state_in = lcet_pkg::S_MUL_WAIT;
         end
         lcet_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = lcet_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lcet_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      phase_in        = phase_ff;
      action_in       = action_ff;
      coarse_in       = coarse_ff;
      elapsed_in      = elapsed_ff;
      value_in        = value_ff;
      scaled_in       = scaled_ff;
      leap_in         = leap_ff;
      base_fast_in    = base_fast_ff;
      base_coarse_in  = base_coarse_ff;
      last_elapsed_in = last_elapsed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_value_in    = rsp_value_ff;
      rsp_leap_in     = rsp_leap_ff;
      mul_start       = 1'b0;
      mul_a           = elapsed_ff;
      mul_b           = lcet_pkg::MS_SCALE;
      div_start       = 1'b0;
      div_a           = mul_product;
      div_d           = {1'b0, freq_ff};

      unique case (state_ff)
         lcet_pkg::S_IDLE: begin
            if (req_fire) begin
               action_in = lcet_pkg::lcet_action_type'(req_action);
               coarse_in = req_coarse_ticks;
               leap_in   = 1'b0;
               value_in  = '0;
               unique case (req_action)
                  lcet_pkg::ACT_RESTART: begin
                     // new baseline; finishing stores zero as the last count
                     base_fast_in   = {1'b0, req_fast_count};
                     base_coarse_in = req_coarse_ticks;
                     elapsed_in     = '0;
                  end
                  lcet_pkg::ACT_READ_MS,
                  lcet_pkg::ACT_READ_US: begin
                     elapsed_in = elapsed_new;
                     phase_in   = lcet_pkg::PH_MS;
                     mul_start  = 1'b1;
                     mul_a      = elapsed_new;
                     mul_b      = lcet_pkg::MS_SCALE;
                  end
                  default: begin
                     // unused action leaves the last count as it is
                     elapsed_in = last_elapsed_ff;
                  end
               endcase
            end
         end
         lcet_pkg::S_MUL_WAIT: begin
            if (mul_status.done) begin
               div_start = 1'b1;
               div_a     = mul_product;
               div_d     = (phase_ff == lcet_pkg::PH_OFF) ? lcet_pkg::MS_SCALE
                                                          : {1'b0, freq_ff};
            end
         end
         lcet_pkg::S_DIV_WAIT: begin
            if (div_status.done) begin
               if (phase_ff == lcet_pkg::PH_OFF) begin
                  scaled_in = div_quotient;
               end else begin
                  value_in = div_quotient;
               end
            end
         end
         lcet_pkg::S_CHECK: begin
            if (leap_hit) begin
               // offset ms back to fast ticks
               phase_in  = lcet_pkg::PH_OFF;
               mul_start = 1'b1;
               mul_a     = off64;
               mul_b     = {1'b0, freq_ff};
            end else if (action_ff != lcet_pkg::ACT_READ_MS) begin
               phase_in  = lcet_pkg::PH_US;
               mul_start = 1'b1;
               mul_a     = elapsed_ff;
               mul_b     = lcet_pkg::US_SCALE;
            end
         end
         lcet_pkg::S_ADJUST: begin
            base_fast_in = base_fast_ff + adjust;
            elapsed_in   = elapsed_adj;
            leap_in      = 1'b1;
            mul_start    = 1'b1;
            mul_a        = elapsed_adj;
            if (action_ff == lcet_pkg::ACT_READ_MS) begin
               phase_in = lcet_pkg::PH_MS2;
               mul_b    = lcet_pkg::MS_SCALE;
            end else begin
               phase_in = lcet_pkg::PH_US;
               mul_b    = lcet_pkg::US_SCALE;
            end
         end
         lcet_pkg::S_FINISH: begin
            if (out_free) begin
               last_elapsed_in = elapsed_ff;
               rsp_valid_in    = 1'b1;
               rsp_value_in    = value_ff[31:0];
               rsp_leap_in     = leap_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // register port: one 63-bit register at offset 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign freq_in    = (csr_write && !csr_paddr[lcet_pkg::CSR_ADDR_W-1])
                       ? csr_pwdata[lcet_pkg::FREQ_W-1:0] : freq_ff;
   assign csr_prdata = csr_paddr[lcet_pkg::CSR_ADDR_W-1] ? '0 : {1'b0, freq_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lcet_pkg::S_IDLE;
         rsp_valid_ff    <= 1'b0;
         freq_ff         <= lcet_pkg::FREQ_RESET;
         base_fast_ff    <= '0;
         base_coarse_ff  <= '0;
         last_elapsed_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         freq_ff         <= freq_in;
         base_fast_ff    <= base_fast_in;
         base_coarse_ff  <= base_coarse_in;
         last_elapsed_ff <= last_elapsed_in;
      end
      phase_ff     <= phase_in;
      action_ff    <= action_in;
      coarse_ff    <= coarse_in;
      elapsed_ff   <= elapsed_in;
      value_ff     <= value_in;
      scaled_ff    <= scaled_in;
      leap_ff      <= leap_in;
      rsp_value_ff <= rsp_value_in;
      rsp_leap_ff  <= rsp_leap_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elapsed_value = rsp_value_ff;
   assign rsp_leap_seen     = rsp_leap_ff;

   // a request is taken only with both units quiet
   `LCET_ASSERT_NOW(a_idle_units_quiet, clock, reset, req_ready, !mul_status.busy && !div_status.busy, "request accepted while a unit is busy")
   // multiplier and divider never run at once
   `LCET_ASSERT_NOW(a_units_exclusive, clock, reset, mul_status.busy, !div_status.busy, "multiplier and divider busy together")
   // restart goes straight to the result stage
   `LCET_ASSERT_NEXT(a_restart_short, clock, reset, req_fire && req_action == lcet_pkg::ACT_RESTART, state_ff == lcet_pkg::S_FINISH, "restart did not go to finish")

endmodule

`default_nettype wire
